### hw/rtl/hrrd_pkg.sv
// ----------------------------------------------------------------------------
// hrrd_pkg
// shared types, character codes and match tables for the request detector
// ----------------------------------------------------------------------------
package hrrd_pkg;

	localparam int NCHRS          = 3;
	localparam int HIST_W         = (NCHRS - 1) * 8;
	localparam int VER_PREFIX_LEN = 7;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_G  = 8'h47;
	localparam logic [7:0] CH_H  = 8'h48;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_1  = 8'h31;

	localparam logic [1:0] PH_METHOD  = 2'd0;
	localparam logic [1:0] PH_VERSION = 2'd1;
	localparam logic [1:0] PH_HEADER  = 2'd2;
	localparam logic [1:0] PH_DONE    = 2'd3;

	localparam logic [1:0] VD_WAIT     = 2'd0;
	localparam logic [1:0] VD_HDR_END  = 2'd1;
	localparam logic [1:0] VD_PASS     = 2'd2;
	localparam logic [1:0] VD_PRESSURE = 2'd3;

	typedef struct packed {
		logic       buffer_pressure;
		logic       first_byte;
		logic [7:0] data_byte;
	} beat_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic       ready_res;
	} result_t;

	// bytes of the method that follow the leading G or H
	function automatic logic [7:0] method_tail(input logic is_head, input logic [2:0] idx);
		logic [7:0] ch;
		ch = CH_SP;
		if (is_head) begin
			unique case (idx)
				3'd0:    ch = 8'h45;
				3'd1:    ch = 8'h41;
				3'd2:    ch = 8'h44;
				default: ch = CH_SP;
			endcase
		end else begin
			unique case (idx)
				3'd0:    ch = 8'h45;
				3'd1:    ch = 8'h54;
				default: ch = CH_SP;
			endcase
		end
		return ch;
	endfunction

	// "HTTP/1."
	function automatic logic [7:0] ver_prefix(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = 8'h48;
			3'd1:    ch = 8'h54;
			3'd2:    ch = 8'h54;
			3'd3:    ch = 8'h50;
			3'd4:    ch = 8'h2F;
			3'd5:    ch = 8'h31;
			default: ch = 8'h2E;
		endcase
		return ch;
	endfunction

endpackage

### hw/rtl/hrrd_parser.sv
// ----------------------------------------------------------------------------
// hrrd_parser
// parse state registers and the single-byte update of the request scan
// ----------------------------------------------------------------------------
module hrrd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             check_version,
	input  hrrd_pkg::beat_t  beat,
	output hrrd_pkg::result_t res
);
	import hrrd_pkg::*;

	logic [1:0]        phase_q, phase_d;
	logic [2:0]        mpos_q, mpos_d;
	logic              is_head_q, is_head_d;
	logic [1:0]        runs_q, runs_d;
	logic              in_run_q, in_run_d;
	logic [3:0]        vpos_q, vpos_d;
	logic [HIST_W-1:0] hist_q, hist_d;
	logic [1:0]        verdict_q, verdict_d;

	logic [HIST_W-1:0] hist_e;
	logic [1:0]        v;
	logic [2:0]        idx;
	logic [2:0]        mlen;
	logic [7:0]        c;
	logic              go;

	always_comb begin
		c         = beat.data_byte;
		phase_d   = phase_q;
		mpos_d    = mpos_q;
		is_head_d = is_head_q;
		runs_d    = runs_q;
		in_run_d  = in_run_q;
		vpos_d    = vpos_q;
		hist_e    = hist_q;
		verdict_d = verdict_q;
		if (beat.first_byte) begin
			phase_d   = PH_METHOD;
			mpos_d    = '0;
			is_head_d = 1'b0;
			runs_d    = '0;
			in_run_d  = 1'b0;
			vpos_d    = '0;
			hist_e    = '0;
			verdict_d = VD_WAIT;
		end
		v    = VD_WAIT;
		idx  = mpos_d - 3'd1;
		mlen = is_head_d ? 3'd4 : 3'd3;
		go   = 1'b0;
		unique case (phase_d)
			PH_METHOD: begin
				if (mpos_d == 3'd0) begin
					if (c == CH_G) begin
						is_head_d = 1'b0;
						mpos_d    = 3'd1;
					end else if (c == CH_H) begin
						is_head_d = 1'b1;
						mpos_d    = 3'd1;
					end else begin
						v = VD_PASS;
					end
				end else if (idx >= mlen || c != method_tail(is_head_d, idx)) begin
					v = VD_PASS;
				end else begin
					mpos_d = mpos_d + 3'd1;
					if (idx + 3'd1 == mlen) begin
						if (check_version) begin
							phase_d  = PH_VERSION;
							runs_d   = 2'd1;
							in_run_d = 1'b1;
							vpos_d   = '0;
						end else begin
							phase_d = PH_HEADER;
						end
					end
				end
			end
			PH_VERSION: begin
				if (vpos_d == 4'd0) begin
					if (c == CH_SP) begin
						if (!in_run_d) begin
							runs_d   = runs_d + 2'd1;
							in_run_d = 1'b1;
						end
					end else if (c == CH_CR || c == CH_LF) begin
						v = VD_PASS;
					end else if (runs_d != 2'd2) begin
						in_run_d = 1'b0;
					end else begin
						go = 1'b1;
					end
				end else begin
					go = 1'b1;
				end
				if (go) begin
					if (vpos_d < 4'(VER_PREFIX_LEN)) begin
						if (c != ver_prefix(vpos_d[2:0])) begin
							v = VD_PASS;
						end else begin
							vpos_d = vpos_d + 4'd1;
						end
					end else if (c == CH_0 || c == CH_1) begin
						phase_d = PH_HEADER;
					end else begin
						v = VD_PASS;
					end
				end
			end
			PH_HEADER: begin
				if (c == CH_LF && (hist_e[7:0] == CH_LF ||
						(hist_e[7:0] == CH_CR && hist_e[15:8] == CH_LF))) begin
					v = VD_HDR_END;
				end
			end
			default: begin
				v = VD_WAIT;
			end
		endcase
		res.ready_res = 1'b0;
		if (verdict_d == VD_WAIT) begin
			if (beat.buffer_pressure) begin
				v = VD_PRESSURE;
			end
			if (v != VD_WAIT) begin
				verdict_d     = v;
				phase_d       = PH_DONE;
				res.ready_res = 1'b1;
			end
		end
		res.verdict = verdict_d;
		hist_d      = {hist_e[HIST_W-9:0], c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_METHOD;
			mpos_q    <= '0;
			is_head_q <= 1'b0;
			runs_q    <= '0;
			in_run_q  <= 1'b0;
			vpos_q    <= '0;
			hist_q    <= '0;
			verdict_q <= VD_WAIT;
		end else if (en) begin
			phase_q   <= phase_d;
			mpos_q    <= mpos_d;
			is_head_q <= is_head_d;
			runs_q    <= runs_d;
			in_run_q  <= in_run_d;
			vpos_q    <= vpos_d;
			hist_q    <= hist_d;
			verdict_q <= verdict_d;
		end
	end

endmodule

### hw/rtl/http_request_ready_detector_unit.sv
// ----------------------------------------------------------------------------
// http_request_ready_detector_unit
// per-byte detector that decides when a received request may be delivered
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one received byte per beat; tuser marks the first byte of
//   a new connection and buffer pressure. m_axis returns one beat per input
//   beat with the ready pulse and the held verdict.
//   cfg_wr_en/cfg_wr_data write the version check enable; write it only
//   while no beat is in flight.
//   an input beat passes through the input register, then the parse update
//   feeding the result register. one beat per cycle is sustained while
//   m_axis accepts; the parse state update is the only loop.
//   reset clears the parse state to method check, the verdict to waiting,
//   and sets the version check enable.
//   when m_axis stalls the result register and the input register hold their
//   beats; s_axis_tready drops only once both are full.
// ----------------------------------------------------------------------------
module http_request_ready_detector_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // data_byte
	input  logic [1:0] s_axis_tuser,   // first_byte, buffer_pressure
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // ready_res, verdict[1:0], zero fill
);
	import hrrd_pkg::*;

	logic              check_version_q;
	logic              vld_s1;
	beat_t             beat_s1;
	logic              out_vld_q;
	result_t           res_q;
	result_t           res_d;
	logic              adv;

	assign adv           = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_version_q <= 1'b1;
		end else if (cfg_wr_en) begin
			check_version_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			beat_s1.data_byte       <= s_axis_tdata;
			beat_s1.first_byte      <= s_axis_tuser[0];
			beat_s1.buffer_pressure <= s_axis_tuser[1];
		end
	end

	hrrd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.check_version (check_version_q),
		.beat          (beat_s1),
		.res           (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, res_q.verdict, res_q.ready_res};

	a_ready_has_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[2:1] != VD_WAIT))
		else $error("ready pulse without a verdict");

	a_s1_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> vld_s1)
		else $error("input stage beat lost while stalled");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_vld_q)
		else $error("result register not loaded on advance");

endmodule
